>>> rtl/core/cstnh_pkg.sv
// Shared codes, state type and cell control group for the cost-sorted next-hop table.
package cstnh_pkg;

  // Command codes carried in the request
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_UPDATED   = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_PRESENT   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int FACE_W   = 16;
  localparam int COST_W   = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int IN_W     = 56;
  localparam int OUT_W    = 64;

  typedef enum logic {
    CTL_IDLE,
    CTL_APPLY
  } ctl_state_t;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    logic capture;    // latch compare flags for the incoming request
    logic commit;     // load next contents
    logic do_insert;  // place the request entry at its sorted slot
    logic do_remove;  // close the gap left by the matching entry
  } cell_ctrl_t;

endpackage

>>> rtl/core/cstnh_cell.sv
// One slot of the sorted table: holds an entry and shifts with its neighbors.
module cstnh_cell #(
  parameter int FACE_W = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cstnh_pkg::cell_ctrl_t      ctrl,
  input  logic [FACE_W-1:0]          in_face,
  input  logic [cstnh_pkg::COST_W-1:0] in_cost,
  input  logic [FACE_W-1:0]          new_face,
  input  logic [cstnh_pkg::COST_W-1:0] new_cost,
  input  logic                       left_v,
  input  logic [FACE_W-1:0]          left_face,
  input  logic [cstnh_pkg::COST_W-1:0] left_cost,
  input  logic                       left_before,
  input  logic                       left_lr,
  input  logic                       right_v,
  input  logic [FACE_W-1:0]          right_face,
  input  logic [cstnh_pkg::COST_W-1:0] right_cost,
  input  logic                       right_le,
  input  logic                       ahead,
  output logic                       v,
  output logic [FACE_W-1:0]          face,
  output logic [cstnh_pkg::COST_W-1:0] cost,
  output logic                       match,
  output logic                       le,
  output logic                       lr,
  output logic                       ins_here,
  output logic                       v_next,
  output logic [FACE_W-1:0]          face_next,
  output logic [cstnh_pkg::COST_W-1:0] cost_next
);

  logic                         r_v;
  logic [FACE_W-1:0]            r_face;
  logic [cstnh_pkg::COST_W-1:0] r_cost;
  logic                         rp_v;
  logic [FACE_W-1:0]            rp_face;
  logic [cstnh_pkg::COST_W-1:0] rp_cost;

  // Contents of this slot and of the slot to the left once the matching entry is gone
  assign r_v     = ahead ? v : right_v;
  assign r_face  = ahead ? face : right_face;
  assign r_cost  = ahead ? cost : right_cost;
  assign rp_v    = left_before ? left_v : v;
  assign rp_face = left_before ? left_face : face;
  assign rp_cost = left_before ? left_cost : cost;

  assign lr       = ahead ? le : right_le;
  assign ins_here = ctrl.do_insert & ~lr & left_lr;

  always_comb begin
    v_next    = v;
    face_next = face;
    cost_next = cost;
    if (ctrl.do_insert) begin
      if (lr) begin
        v_next    = r_v;
        face_next = r_face;
        cost_next = r_cost;
      end else if (left_lr) begin
        v_next    = 1'b1;
        face_next = new_face;
        cost_next = new_cost;
      end else begin
        v_next    = rp_v;
        face_next = rp_face;
        cost_next = rp_cost;
      end
    end else if (ctrl.do_remove) begin
      v_next    = r_v;
      face_next = r_face;
      cost_next = r_cost;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (ctrl.commit) begin
      v <= v_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      face <= face_next;
      cost <= cost_next;
    end
    if (ctrl.capture) begin
      match <= v && (face == in_face);
      le    <= v && (cost <= in_cost);
    end
  end

endmodule

>>> rtl/core/cost_sorted_next_hop_table_unit.sv
// Top level of the cost-sorted next-hop table: sequencer, row of cells and result register.
// A request accepted in the idle step has its compare flags captured at accept; in the
//   apply step the row shifts and the result loads into the output register.
// Requests do not overlap: s_tready stays low in the apply step, through the compare-then-shift pass.
// A waiting result lets one request in; that request then holds in the apply step, with
//   s_tready low, until the output slot frees up.
// Reset (rst, synchronous): empties the table and drops any pending result; entry
//   contents are left as they are and are never read while invalid.
module cost_sorted_next_hop_table_unit #(
  parameter int MAX_HOPS  = 16,
  parameter int FACE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // s_tdata, low bit up: cmd[1:0], face_id[17:2], cost[49:18], zero fill[55:50]
  input  logic [cstnh_pkg::IN_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // m_tdata, low bit up: status[2:0], position[6:3], entry_count[11:7],
  //   best_face[27:12], best_cost[59:28], zero fill[63:60]
  output logic [cstnh_pkg::OUT_W-1:0] m_tdata
);

  // Faces compare in their low FACE_BITS bits, never wider than the field
  localparam int FW    = (FACE_BITS < cstnh_pkg::FACE_W) ? FACE_BITS : cstnh_pkg::FACE_W;
  localparam int IDX_W = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
  localparam int CNT_W = $clog2(MAX_HOPS + 1);

  // Request fields straight off the bus
  logic [cstnh_pkg::CMD_W-1:0]  in_cmd;
  logic [FW-1:0]                in_face;
  logic [cstnh_pkg::COST_W-1:0] in_cost;

  assign in_cmd  = s_tdata[1:0];
  assign in_face = s_tdata[2 +: FW];
  assign in_cost = s_tdata[18 +: cstnh_pkg::COST_W];

  cstnh_pkg::ctl_state_t state, state_next;

  // Held request
  logic [cstnh_pkg::CMD_W-1:0]  req_cmd;
  logic [FW-1:0]                req_face;
  logic [cstnh_pkg::COST_W-1:0] req_cost;

  logic [CNT_W-1:0] count, count_next;

  // Result register
  logic [cstnh_pkg::STATUS_W-1:0] res_status;
  logic [cstnh_pkg::POS_W-1:0]    res_pos;
  logic [cstnh_pkg::COUNT_W-1:0]  res_count;
  logic [cstnh_pkg::FACE_W-1:0]   res_face;
  logic [cstnh_pkg::COST_W-1:0]   res_cost;

  cstnh_pkg::cell_ctrl_t ctrl;

  // Neighbor links, padded by one slot on each end
  logic                         v_ext    [MAX_HOPS+1:0];
  logic [FW-1:0]                face_ext [MAX_HOPS+1:0];
  logic [cstnh_pkg::COST_W-1:0] cost_ext [MAX_HOPS+1:0];
  logic                         le_ext   [MAX_HOPS+1:0];
  logic                         lr_ext   [MAX_HOPS+1:0];
  logic                         bf_ext   [MAX_HOPS+1:0];

  logic [MAX_HOPS-1:0] match_vec;
  logic [MAX_HOPS-1:0] ins_vec;
  logic [MAX_HOPS-1:0] v_vec;
  logic [MAX_HOPS-1:0] before_vec;
  logic [MAX_HOPS-1:0] fill_mask;

  logic                         head_v_next;
  logic [FW-1:0]                head_face_next;
  logic [cstnh_pkg::COST_W-1:0] head_cost_next;

  logic                           found;
  logic                           slot_free;
  logic [IDX_W-1:0]               match_idx;
  logic [IDX_W-1:0]               ins_idx;
  logic [cstnh_pkg::STATUS_W-1:0] status_sel;
  logic [IDX_W-1:0]               pos_sel;

  // Tie off the ends of the row
  assign v_ext[0]             = 1'b0;
  assign face_ext[0]          = '0;
  assign cost_ext[0]          = '0;
  assign le_ext[0]            = 1'b0;
  assign lr_ext[0]            = 1'b1;
  assign bf_ext[0]            = 1'b1;
  assign v_ext[MAX_HOPS+1]    = 1'b0;
  assign face_ext[MAX_HOPS+1] = '0;
  assign cost_ext[MAX_HOPS+1] = '0;
  assign le_ext[MAX_HOPS+1]   = 1'b0;
  assign lr_ext[MAX_HOPS+1]   = 1'b0;
  assign bf_ext[MAX_HOPS+1]   = 1'b1;

  // A slot lies ahead of the matching entry when neither it nor any slot below it matched
  always_comb begin
    for (int i = 0; i < MAX_HOPS; i++) begin
      before_vec[i] = ~|(match_vec & ~({MAX_HOPS{1'b1}} << (i + 1)));
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_HOPS; g++) begin : g_cell
      logic                         vn;
      logic [FW-1:0]                fn;
      logic [cstnh_pkg::COST_W-1:0] cn;

      assign bf_ext[g+1] = before_vec[g];
      assign v_vec[g]    = v_ext[g+1];

      cstnh_cell #(
        .FACE_W(FW)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .in_face    (in_face),
        .in_cost    (in_cost),
        .new_face   (req_face),
        .new_cost   (req_cost),
        .left_v     (v_ext[g]),
        .left_face  (face_ext[g]),
        .left_cost  (cost_ext[g]),
        .left_before(bf_ext[g]),
        .left_lr    (lr_ext[g]),
        .right_v    (v_ext[g+2]),
        .right_face (face_ext[g+2]),
        .right_cost (cost_ext[g+2]),
        .right_le   (le_ext[g+2]),
        .ahead      (before_vec[g]),
        .v          (v_ext[g+1]),
        .face       (face_ext[g+1]),
        .cost       (cost_ext[g+1]),
        .match      (match_vec[g]),
        .le         (le_ext[g+1]),
        .lr         (lr_ext[g+1]),
        .ins_here   (ins_vec[g]),
        .v_next     (vn),
        .face_next  (fn),
        .cost_next  (cn)
      );

      if (g == 0) begin : g_head
        assign head_v_next    = vn;
        assign head_face_next = fn;
        assign head_cost_next = cn;
      end
    end
  endgenerate

  // Turn the one-hot match and insert flags into slot numbers
  always_comb begin
    match_idx = '0;
    ins_idx   = '0;
    for (int i = 0; i < MAX_HOPS; i++) begin
      if (match_vec[i]) match_idx = match_idx | IDX_W'(i);
      if (ins_vec[i])   ins_idx   = ins_idx | IDX_W'(i);
    end
  end

  assign found     = |match_vec;
  assign slot_free = ~m_tvalid | m_tready;

  // Sequencer: decide the edit, hold it until the output slot frees up
  always_comb begin
    state_next     = state;
    ctrl           = '0;
    status_sel     = cstnh_pkg::ST_NOT_FOUND;
    pos_sel        = '0;
    s_tready       = 1'b0;
    case (state)
      cstnh_pkg::CTL_IDLE: begin
        s_tready     = 1'b1;
        ctrl.capture = s_tvalid;
        if (s_tvalid) state_next = cstnh_pkg::CTL_APPLY;
      end
      cstnh_pkg::CTL_APPLY: begin
        case (req_cmd)
          cstnh_pkg::CMD_ADD: begin
            if (found) begin
              ctrl.do_remove = 1'b1;
              ctrl.do_insert = 1'b1;
              status_sel     = cstnh_pkg::ST_UPDATED;
              pos_sel        = ins_idx;
            end else if (count < CNT_W'(MAX_HOPS)) begin
              ctrl.do_insert = 1'b1;
              status_sel     = cstnh_pkg::ST_INSERTED;
              pos_sel        = ins_idx;
            end else begin
              status_sel     = cstnh_pkg::ST_FULL;
            end
          end
          cstnh_pkg::CMD_REMOVE: begin
            if (found) begin
              ctrl.do_remove = 1'b1;
              status_sel     = cstnh_pkg::ST_REMOVED;
              pos_sel        = match_idx;
            end
          end
          default: begin
            // query, and the unused code acts as one
            if (found) begin
              status_sel = cstnh_pkg::ST_PRESENT;
              pos_sel    = match_idx;
            end
          end
        endcase
        ctrl.commit = slot_free;
        if (slot_free) state_next = cstnh_pkg::CTL_IDLE;
      end
      default: begin
        state_next = cstnh_pkg::CTL_IDLE;
      end
    endcase
  end

  assign count_next = count - CNT_W'(ctrl.do_remove & ~ctrl.do_insert)
                            + CNT_W'(ctrl.do_insert & ~ctrl.do_remove);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cstnh_pkg::CTL_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.commit) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Hold the request; load the result on commit
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      req_cmd  <= in_cmd;
      req_face <= in_face;
      req_cost <= in_cost;
    end
    if (ctrl.commit) begin
      res_status <= status_sel;
      res_pos    <= cstnh_pkg::POS_W'(pos_sel);
      res_count  <= cstnh_pkg::COUNT_W'(count_next);
      res_face   <= head_v_next ? cstnh_pkg::FACE_W'(head_face_next) : '0;
      res_cost   <= head_v_next ? head_cost_next : '0;
    end
  end

  assign m_tdata = {4'd0, res_cost, res_face, res_count, res_pos, res_status};

  // Expected valid pattern: the low count slots
  always_comb begin
    for (int i = 0; i < MAX_HOPS; i++) begin
      fill_mask[i] = (CNT_W'(i) < count);
    end
  end

  // Faces are unique, so at most one slot can match
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    (state == cstnh_pkg::CTL_APPLY) |-> $onehot0(match_vec))
    else $error("more than one slot matched the request face");

  // Valid slots always form a prefix as long as the entry count
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    v_vec == fill_mask)
    else $error("valid slots disagree with the entry count");

  // A commit always leaves a result waiting
  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    ctrl.commit |=> m_tvalid)
    else $error("commit without a result");

  // An insert lands in exactly one slot
  a_one_insert: assert property (@(posedge clk) disable iff (rst)
    ctrl.do_insert |-> $onehot(ins_vec))
    else $error("insert slot not unique");

endmodule
